// ===== hw/rtl/pbm_pkg.sv =====
package pbm_pkg;

   localparam int ACTION_W   = 3;
   localparam int TARGET_W   = 7;
   localparam int DIR_W      = 2;
   localparam int POS_W      = 18;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int MARGIN_W   = 6;
   localparam int POT_REG_W  = 10;

   localparam logic [POT_REG_W-1:0] POT_MIN_RESET = 10'd0;
   localparam logic [POT_REG_W-1:0] POT_MAX_RESET = 10'd1023;
   localparam logic [MARGIN_W-1:0]  MARGIN_RESET  = 6'd2;
   localparam int                   FULL_SCALE    = 100;

   typedef enum logic [DIR_W-1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_BACK = 2'd2
   } dir_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_STOP    = 3'd0,
      ACT_FWD     = 3'd1,
      ACT_BACK    = 3'd2,
      ACT_SEEK    = 3'd3,
      ACT_BUTTONS = 3'd4
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POT_MIN = 2'd0,
      CSR_POT_MAX = 2'd1,
      CSR_MARGIN  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_HOLD   = 2'd2
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hw/rtl/pbm_if.sv =====
interface pbm_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                          valid;
   logic                          ready;
   logic [pbm_pkg::ACTION_W-1:0]  action;
   logic [SAMPLE_BITS-1:0]        pot_sample;
   logic [pbm_pkg::TARGET_W-1:0]  target_percent;
   logic                          btn_fwd;
   logic                          btn_back;

   modport source (
      output valid, action, pot_sample, target_percent, btn_fwd, btn_back,
      input  ready
   );
   modport sink (
      input  valid, action, pot_sample, target_percent, btn_fwd, btn_back,
      output ready
   );
endinterface

interface pbm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       drive_forward_n;
   logic                       drive_back_n;
   logic [pbm_pkg::DIR_W-1:0]  direction;
   logic [pbm_pkg::POS_W-1:0]  position_percent;
   logic                       pins_changed;
   logic                       span_error;

   modport source (
      output valid, drive_forward_n, drive_back_n, direction, position_percent,
             pins_changed, span_error,
      input  ready
   );
   modport sink (
      input  valid, drive_forward_n, drive_back_n, direction, position_percent,
             pins_changed, span_error,
      output ready
   );
endinterface

// ===== hw/rtl/pbm_div.sv =====
module pbm_div #(
   parameter int NW = 17,
   parameter int DW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NW-1:0]         dividend,
   input  logic [DW-1:0]         divisor,
   output logic [NW-1:0]         quotient,
   output pbm_pkg::div_stat_type stat
);
   localparam int CNT_W = $clog2(NW);

   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             active_ff, active_in;
   logic             done_ff, done_in;

   logic [DW:0] shifted;
   logic [DW:0] trial;
   logic        fits;

   // one restoring step: shift in the next dividend bit, try the subtract
   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in    = dividend;
         rem_in    = '0;
         div_in    = divisor;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? trial[DW-1:0] : shifted[DW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NW - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = active_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/pbm_decide.sv =====
module pbm_decide #(
   parameter int PW = 18
) (
   input  logic signed [PW-1:0]            pos,
   input  logic [pbm_pkg::ACTION_W-1:0]    action,
   input  logic [pbm_pkg::TARGET_W-1:0]    target,
   input  logic                            btn_fwd,
   input  logic                            btn_back,
   input  logic [pbm_pkg::MARGIN_W-1:0]    margin,
   input  logic                            span_err,
   output pbm_pkg::dir_type                next_dir
);
   localparam int CW = PW + 1;

   logic signed [CW-1:0] pos_c;
   logic signed [CW-1:0] mar_c;
   logic signed [CW-1:0] tgt_c;
   logic signed [CW-1:0] fwd_lim;
   pbm_pkg::dir_type     want_fwd;
   pbm_pkg::dir_type     want_back;
   logic                 in_band;

   assign pos_c   = CW'(pos);
   assign mar_c   = CW'($signed({1'b0, margin}));
   assign tgt_c   = CW'($signed({1'b0, target}));
   assign fwd_lim = CW'(pbm_pkg::FULL_SCALE) - mar_c;

   // refuse motion past either end margin
   assign want_fwd  = (pos_c >= fwd_lim) ? pbm_pkg::DIR_STOP : pbm_pkg::DIR_FWD;
   assign want_back = (pos_c <= mar_c)   ? pbm_pkg::DIR_STOP : pbm_pkg::DIR_BACK;
   assign in_band   = (pos_c < tgt_c + mar_c) && (pos_c > tgt_c - mar_c);

   always_comb begin
      next_dir = pbm_pkg::DIR_STOP;
      if (!span_err) begin
         case (action)
            pbm_pkg::ACT_FWD: begin
               next_dir = want_fwd;
            end
            pbm_pkg::ACT_BACK: begin
               next_dir = want_back;
            end
            pbm_pkg::ACT_SEEK: begin
               if (in_band) begin
                  next_dir = pbm_pkg::DIR_STOP;
               end else if (pos_c < tgt_c) begin
                  next_dir = want_back;
               end else begin
                  next_dir = want_fwd;
               end
            end
            pbm_pkg::ACT_BUTTONS: begin
               if (btn_fwd) begin
                  next_dir = want_fwd;
               end else if (btn_back) begin
                  next_dir = want_back;
               end else begin
                  next_dir = pbm_pkg::DIR_STOP;
               end
            end
            default: begin
               next_dir = pbm_pkg::DIR_STOP;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/pot_position_bang_bang_motor_core.sv =====
// A restoring divider retires one quotient bit per cycle over SAMPLE_BITS + 7 bits;
// a new req beat is taken only in the idle state, after the last result has been loaded
// onto rsp, so items do not overlap.
// A result waiting on rsp stalls the next item only once its own division has finished.
// Synchronous active-high reset: motion state stopped (pin outputs are not reset), pot_min 0,
// pot_max full scale, margin 2 percent, no result pending.
module pot_position_bang_bang_motor_core #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   pbm_req_if.sink                          req,
   pbm_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [pbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbm_pkg::CSR_DATA_W-1:0]   csr_data
);
   localparam int PB = (SAMPLE_BITS < pbm_pkg::POT_REG_W) ? SAMPLE_BITS : pbm_pkg::POT_REG_W;
   localparam int NW = SAMPLE_BITS + 7;
   localparam int PW = NW + 1;
   localparam int XW = (PW > pbm_pkg::POS_W) ? PW : pbm_pkg::POS_W;

   logic [PB-1:0]                  pot_min_ff;
   logic [PB-1:0]                  pot_max_ff;
   logic [pbm_pkg::MARGIN_W-1:0]   margin_ff;

   pbm_pkg::state_type state_ff, state_in;
   pbm_pkg::dir_type   motion_ff;
   pbm_pkg::dir_type   next_dir;

   logic [pbm_pkg::ACTION_W-1:0]   action_ff;
   logic [pbm_pkg::TARGET_W-1:0]   target_ff;
   logic                           bf_ff;
   logic                           bb_ff;
   logic                           sign_ff;

   logic                           rsp_valid_ff;
   logic                           fwd_n_ff;
   logic                           back_n_ff;
   logic [pbm_pkg::DIR_W-1:0]      dir_ff;
   logic [pbm_pkg::POS_W-1:0]      pos_ff;
   logic                           changed_ff;
   logic                           err_ff;

   logic                           accept;
   logic                           out_free;
   logic                           load_out;
   logic                           ready_int;

   logic signed [SAMPLE_BITS:0]    diff;
   logic signed [NW:0]             diff_x;
   logic signed [NW:0]             prod;
   logic signed [NW:0]             prod_abs;
   logic signed [PB:0]             span;
   logic signed [PB:0]             span_abs;
   logic                           span_err;

   logic [NW-1:0]                  quotient;
   pbm_pkg::div_stat_type          div_stat;
   logic signed [PW-1:0]           pos;
   logic signed [XW-1:0]           pos_x;

   assign accept   = req.valid && ready_int;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // scale the sample's offset from pot_min by 100 with shifts: 64 + 32 + 4
   assign diff     = $signed({1'b0, req.pot_sample})
                   - $signed({{(SAMPLE_BITS - PB + 1){1'b0}}, pot_min_ff});
   assign diff_x   = (NW + 1)'(diff);
   assign prod     = (diff_x <<< 6) + (diff_x <<< 5) + (diff_x <<< 2);
   assign prod_abs = prod[NW] ? -prod : prod;

   assign span     = $signed({1'b0, pot_max_ff}) - $signed({1'b0, pot_min_ff});
   assign span_abs = span[PB] ? -span : span;
   assign span_err = (span == '0);

   pbm_div #(
      .NW(NW),
      .DW(PB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (prod_abs[NW-1:0]),
      .divisor  (span_abs[PB-1:0]),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // truncation toward zero: divide magnitudes, then restore the sign
   assign pos   = sign_ff ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
   assign pos_x = XW'(pos);

   pbm_decide #(
      .PW(PW)
   ) u_decide (
      .pos      (pos),
      .action   (action_ff),
      .target   (target_ff),
      .btn_fwd  (bf_ff),
      .btn_back (bb_ff),
      .margin   (margin_ff),
      .span_err (span_err),
      .next_dir (next_dir)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pbm_pkg::ST_DIVIDE;
            end
         end
         pbm_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = out_free ? pbm_pkg::ST_IDLE : pbm_pkg::ST_HOLD;
            end
         end
         pbm_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = pbm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ready_int = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         pbm_pkg::ST_IDLE: begin
            ready_int = 1'b1;
         end
         pbm_pkg::ST_DIVIDE: begin
            load_out = div_stat.done && out_free;
         end
         pbm_pkg::ST_HOLD: begin
            load_out = out_free;
         end
         default: begin
            ready_int = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pot_min_ff <= PB'(pbm_pkg::POT_MIN_RESET);
         pot_max_ff <= PB'(pbm_pkg::POT_MAX_RESET);
         margin_ff  <= pbm_pkg::MARGIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pbm_pkg::CSR_POT_MIN: pot_min_ff <= csr_data[PB-1:0];
            pbm_pkg::CSR_POT_MAX: pot_max_ff <= csr_data[PB-1:0];
            pbm_pkg::CSR_MARGIN:  margin_ff  <= csr_data[pbm_pkg::MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbm_pkg::ST_IDLE;
         motion_ff    <= pbm_pkg::DIR_STOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            motion_ff    <= next_dir;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the command fields for the decision at the end of the division
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req.action;
         target_ff <= req.target_percent;
         bf_ff     <= req.btn_fwd;
         bb_ff     <= req.btn_back;
         sign_ff   <= prod[NW] ^ span[PB];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         fwd_n_ff   <= (next_dir != pbm_pkg::DIR_FWD);
         back_n_ff  <= (next_dir != pbm_pkg::DIR_BACK);
         dir_ff     <= next_dir;
         pos_ff     <= span_err ? '0 : pos_x[pbm_pkg::POS_W-1:0];
         changed_ff <= (next_dir != motion_ff);
         err_ff     <= span_err;
      end
   end

   assign req.ready            = ready_int;
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.drive_forward_n  = fwd_n_ff;
   assign rsp.drive_back_n     = back_n_ff;
   assign rsp.direction        = dir_ff;
   assign rsp.position_percent = pos_ff;
   assign rsp.pins_changed     = changed_ff;
   assign rsp.span_error       = err_ff;

endmodule

// ===== hw/rtl/pbm_checker.sv =====
module pbm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          drive_forward_n,
   input logic                          drive_back_n,
   input logic [pbm_pkg::DIR_W-1:0]     direction,
   input logic [pbm_pkg::POS_W-1:0]     position_percent,
   input logic                          span_error
);

   // pins follow the reported direction
   a_pins_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (drive_forward_n == (direction != pbm_pkg::DIR_FWD))
                 && (drive_back_n == (direction != pbm_pkg::DIR_BACK)))
      else $error("pin levels disagree with direction");

   a_span_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && span_error) |-> (direction == pbm_pkg::DIR_STOP)
                                 && (position_percent == '0))
      else $error("zero span did not stop the motor");

   // one item in flight: no new beat right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while an item is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(direction)
                                 && $stable(position_percent))
      else $error("stalled result beat changed");

endmodule

bind pot_position_bang_bang_motor_core pbm_checker u_pbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .drive_forward_n  (rsp.drive_forward_n),
   .drive_back_n     (rsp.drive_back_n),
   .direction        (rsp.direction),
   .position_percent (rsp.position_percent),
   .span_error       (rsp.span_error)
);

// ===== test/pot_position_bang_bang_motor_core_tb.sv =====
module pot_position_bang_bang_motor_core_tb;

   localparam int SAMPLE_BITS   = 10;
   localparam int ITEMS_PER_SET = 84;
   localparam int SETTLE_CYCLES = 2 * (SAMPLE_BITS + 9);
   localparam int CYCLE_LIMIT   = 600000;

   typedef struct packed {
      logic [pbm_pkg::ACTION_W-1:0] action;
      logic [SAMPLE_BITS-1:0]       sample;
      logic [pbm_pkg::TARGET_W-1:0] target;
      logic                         btn_fwd;
      logic                         btn_back;
   } motor_cmd_type;

   typedef struct packed {
      logic                       drive_forward_n;
      logic                       drive_back_n;
      logic [pbm_pkg::DIR_W-1:0]  direction;
      logic [pbm_pkg::POS_W-1:0]  position;
      logic                       pins_changed;
      logic                       span_error;
   } motor_result_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [pbm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pbm_pkg::CSR_DATA_W-1:0] csr_data;

   pbm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   pbm_rsp_if                              rsp_bus ();

   pot_position_bang_bang_motor_core #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Own copy of the block's registers and motion state
   logic [pbm_pkg::POT_REG_W-1:0] span_lo;
   logic [pbm_pkg::POT_REG_W-1:0] span_hi;
   logic [pbm_pkg::MARGIN_W-1:0]  band;
   pbm_pkg::dir_type              motion;

   motor_cmd_type    cmd_backlog[$];
   motor_result_type expected_motion[$];
   motor_cmd_type    cmd_on_bus;

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned error_count;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.action = '0;
      req_bus.pot_sample = '0;
      req_bus.target_percent = '0;
      req_bus.btn_fwd = 1'b0;
      req_bus.btn_back = 1'b0;
      rsp_bus.ready = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic pbm_pkg::dir_type forward_limit(longint pos, longint margin);
      return (pos >= pbm_pkg::FULL_SCALE - margin) ? pbm_pkg::DIR_STOP : pbm_pkg::DIR_FWD;
   endfunction

   function automatic pbm_pkg::dir_type backward_limit(longint pos, longint margin);
      return (pos <= margin) ? pbm_pkg::DIR_STOP : pbm_pkg::DIR_BACK;
   endfunction

   // Advance the motion state by one command and return the beat it should produce
   function automatic motor_result_type predict_motion(motor_cmd_type cmd);
      longint           span;
      longint           pos;
      longint           margin;
      longint           target;
      pbm_pkg::dir_type next;
      motor_result_type res;
      span   = longint'(span_hi) - longint'(span_lo);
      margin = longint'(band);
      target = longint'(cmd.target);
      pos    = 0;
      next   = pbm_pkg::DIR_STOP;
      if (span != 0) begin
         pos = ((longint'(cmd.sample) - longint'(span_lo)) * pbm_pkg::FULL_SCALE) / span;
         case (pbm_pkg::action_type'(cmd.action))
            pbm_pkg::ACT_FWD: begin
               next = forward_limit(pos, margin);
            end
            pbm_pkg::ACT_BACK: begin
               next = backward_limit(pos, margin);
            end
            pbm_pkg::ACT_SEEK: begin
               if (pos < target + margin && pos > target - margin)
                  next = pbm_pkg::DIR_STOP;
               else if (pos < target)
                  next = backward_limit(pos, margin);
               else
                  next = forward_limit(pos, margin);
            end
            pbm_pkg::ACT_BUTTONS: begin
               if (cmd.btn_fwd)
                  next = forward_limit(pos, margin);
               else if (cmd.btn_back)
                  next = backward_limit(pos, margin);
               else
                  next = pbm_pkg::DIR_STOP;
            end
            default: begin
               next = pbm_pkg::DIR_STOP;
            end
         endcase
      end
      res.drive_forward_n = (next != pbm_pkg::DIR_FWD);
      res.drive_back_n    = (next != pbm_pkg::DIR_BACK);
      res.direction       = next;
      res.position        = pos[pbm_pkg::POS_W-1:0];
      res.pins_changed    = (next != motion);
      res.span_error      = (span == 0);
      motion = next;
      return res;
   endfunction

   function automatic motor_cmd_type make_cmd(int action, int sample, int target, bit fwd,
                                              bit back);
      motor_cmd_type cmd;
      cmd.action   = action[pbm_pkg::ACTION_W-1:0];
      cmd.sample   = sample[SAMPLE_BITS-1:0];
      cmd.target   = target[pbm_pkg::TARGET_W-1:0];
      cmd.btn_fwd  = fwd;
      cmd.btn_back = back;
      return cmd;
   endfunction

   // Aim half the samples at the margin, end-limit and seek-band edges
   function automatic motor_cmd_type random_cmd();
      motor_cmd_type cmd;
      longint        pct;
      longint        raw;
      int unsigned   pick;
      if ($urandom_range(99) < 8)
         pick = $urandom_range(7, 5);
      else
         pick = $urandom_range(pbm_pkg::ACT_BUTTONS, pbm_pkg::ACT_STOP);
      cmd.action = pick[pbm_pkg::ACTION_W-1:0];
      if ($urandom_range(99) < 10)
         pick = $urandom_range(127, 101);
      else
         pick = $urandom_range(100, 0);
      cmd.target   = pick[pbm_pkg::TARGET_W-1:0];
      cmd.btn_fwd  = 1'($urandom_range(1));
      cmd.btn_back = 1'($urandom_range(1));
      case ($urandom_range(7))
         0: pct = longint'(band);
         1: pct = pbm_pkg::FULL_SCALE - longint'(band);
         2: pct = longint'(cmd.target) + longint'(band);
         3: pct = longint'(cmd.target) - longint'(band);
         default: pct = -1;
      endcase
      if (pct < 0) begin
         pick = $urandom_range((1 << SAMPLE_BITS) - 1);
         cmd.sample = pick[SAMPLE_BITS-1:0];
      end else begin
         raw = longint'(span_lo)
             + (pct * (longint'(span_hi) - longint'(span_lo))) / pbm_pkg::FULL_SCALE
             + longint'($urandom_range(2)) - 1;
         if (raw < 0)
            raw = 0;
         if (raw > (1 << SAMPLE_BITS) - 1)
            raw = (1 << SAMPLE_BITS) - 1;
         cmd.sample = raw[SAMPLE_BITS-1:0];
      end
      return cmd;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Command driver: predict on each accepted beat, then load the next one
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_motion.push_back(predict_motion(cmd_on_bus));
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cmd_on_bus = cmd_backlog.pop_front();
               req_bus.action         <= cmd_on_bus.action;
               req_bus.pot_sample     <= cmd_on_bus.sample;
               req_bus.target_percent <= cmd_on_bus.target;
               req_bus.btn_fwd        <= cmd_on_bus.btn_fwd;
               req_bus.btn_back       <= cmd_on_bus.btn_back;
               req_bus.valid          <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      motor_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_motion.size() == 0) begin
               $error("result beat with no command outstanding");
               error_count++;
            end else begin
               want = expected_motion.pop_front();
               check_field("drive_forward_n", longint'(want.drive_forward_n),
                           longint'(rsp_bus.drive_forward_n));
               check_field("drive_back_n", longint'(want.drive_back_n),
                           longint'(rsp_bus.drive_back_n));
               check_field("direction", longint'(want.direction),
                           longint'(rsp_bus.direction));
               check_field("position_percent", longint'(want.position),
                           longint'(rsp_bus.position_percent));
               check_field("pins_changed", longint'(want.pins_changed),
                           longint'(rsp_bus.pins_changed));
               check_field("span_error", longint'(want.span_error),
                           longint'(rsp_bus.span_error));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(pbm_pkg::csr_index_type idx,
                            logic [pbm_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         pbm_pkg::CSR_POT_MIN: span_lo = data[pbm_pkg::POT_REG_W-1:0];
         pbm_pkg::CSR_POT_MAX: span_hi = data[pbm_pkg::POT_REG_W-1:0];
         pbm_pkg::CSR_MARGIN:  band    = data[pbm_pkg::MARGIN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() > 0 || req_bus.valid || expected_motion.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [pbm_pkg::CSR_DATA_W-1:0] set_lo[8] =
         '{10'd0, 10'd100, 10'd1023, 10'd512, 10'd300, 10'd0, 10'd1022, 10'd0};
      logic [pbm_pkg::CSR_DATA_W-1:0] set_hi[8] =
         '{10'd1023, 10'd900, 10'd0, 10'd512, 10'd700, 10'd1, 10'd1023, 10'd1023};
      logic [pbm_pkg::CSR_DATA_W-1:0] set_band[8] =
         '{10'd0, 10'd50, 10'd10, 10'd2, 10'd63, 10'd5, 10'd25, 10'd2};
      span_lo = pbm_pkg::POT_MIN_RESET;
      span_hi = pbm_pkg::POT_MAX_RESET;
      band    = pbm_pkg::MARGIN_RESET;
      motion  = pbm_pkg::DIR_STOP;
      send_idle_pct = 18;
      rsp_stall_pct = 82;
      error_count = 0;
      cycle_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: end limits, margin edges, seek band, button priority, unused action codes
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_STOP, 512, 50, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_FWD, 0, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_FWD, 1023, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_FWD, 1003, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_FWD, 993, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BACK, 0, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BACK, 20, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BACK, 31, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BACK, 1023, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_SEEK, 512, 50, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_SEEK, 512, 52, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_SEEK, 512, 48, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_SEEK, 0, 100, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_SEEK, 1023, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_SEEK, 512, 127, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_SEEK, 512, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BUTTONS, 512, 0, 1, 1));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BUTTONS, 512, 0, 0, 1));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BUTTONS, 512, 0, 0, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BUTTONS, 1023, 0, 1, 0));
      cmd_backlog.push_back(make_cmd(pbm_pkg::ACT_BUTTONS, 0, 0, 0, 1));
      cmd_backlog.push_back(make_cmd(5, 512, 0, 1, 0));
      cmd_backlog.push_back(make_cmd(6, 0, 64, 0, 1));
      cmd_backlog.push_back(make_cmd(7, 1023, 127, 1, 1));
      for (int n = 0; n < ITEMS_PER_SET; n++)
         cmd_backlog.push_back(random_cmd());
      wait_drained();

      for (int s = 0; s < 8; s++) begin
         // Swap the idle pattern for settings 2 to 4, settings 5 to 7 run at full rate
         if (s >= 2 && s < 5) begin
            send_idle_pct = 82;
            rsp_stall_pct = 18;
         end else if (s >= 5) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         write_reg(pbm_pkg::CSR_POT_MIN, set_lo[s]);
         write_reg(pbm_pkg::CSR_POT_MAX, set_hi[s]);
         write_reg(pbm_pkg::CSR_MARGIN, set_band[s]);
         @(negedge clock);
         for (int n = 0; n < ITEMS_PER_SET; n++)
            cmd_backlog.push_back(random_cmd());
         wait_drained();
      end

      if (error_count == 0 && expected_motion.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
